>>> hdl/line_square_fov_clip_core_defines.svh
// Assertion helpers for the line clipping core.
`ifndef LINE_SQUARE_FOV_CLIP_CORE_DEFINES_SVH
`define LINE_SQUARE_FOV_CLIP_CORE_DEFINES_SVH

`define LSFC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define LSFC_ASSERT_IMPL(label, cond, conseq, msg) \
   `LSFC_ASSERT(label, (cond) |-> (conseq), msg)

`endif

>>> hdl/lsfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lsfc_pkg;
   localparam int QuotBits = 33;
   localparam int DivLat = QuotBits + 1;

   typedef struct packed {
      logic              keep;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } crossing_type;

   typedef struct packed {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic               nzx;
      logic               nzy;
   } side_type;
endpackage
`default_nettype wire

>>> hdl/line_square_fov_clip_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Clips a line, given by a point and a direction, against the square of half side
// csr_fov_half_width centred at the origin and returns the two boundary crossings
// on it when exactly two are found, else zeros. One beat is accepted per clock while
// the result channel is not stalled; the restoring divider, which resolves one quotient bit
// per pipeline stage for all four boundaries in parallel, sets most of the pipeline depth.
// Any back-pressure on the result channel holds the whole pipeline.
`include "line_square_fov_clip_core_defines.svh"
module line_square_fov_clip_core import lsfc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [30:0] csr_fov_half_width,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic signed [31:0] req_line_start_x,
   input  wire logic signed [31:0] req_line_start_y,
   input  wire logic signed [31:0] req_dir_x,
   input  wire logic signed [31:0] req_dir_y,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_crosses_fov,
   output logic signed [31:0] rsp_first_x,
   output logic signed [31:0] rsp_first_y,
   output logic signed [31:0] rsp_second_x,
   output logic signed [31:0] rsp_second_y
);
   logic [30:0]        fov_ff;
   logic               en;
   logic signed [32:0] pos_b, neg_b;

   logic               a_valid_ff, b_valid_ff;
   logic signed [31:0] a_sx_ff, a_sy_ff, a_dx_ff, a_dy_ff;
   logic signed [31:0] b_sx_ff, b_sy_ff, b_dx_ff, b_dy_ff;
   logic signed [64:0] prod [4];

   logic               sv_ff [0:DivLat-1];
   side_type           sd_ff [0:DivLat-1];

   logic [QuotBits-1:0] quot [4];
   logic                qneg [4];
   logic                qovf [4];

   crossing_type       c_in [4];
   crossing_type       c_ff [4];
   logic               c_valid_ff;

   logic               miss_clear, first_in_sq, second_on_edge;

   assign csr_ready = 1'b1;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign pos_b     = {2'b00, fov_ff};
   assign neg_b     = -pos_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         fov_ff <= '0;
      end else if (csr_valid) begin
         fov_ff <= csr_fov_half_width;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= sv_ff[DivLat-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_sx_ff <= req_line_start_x;
         a_sy_ff <= req_line_start_y;
         a_dx_ff <= req_dir_x;
         a_dy_ff <= req_dir_y;
         b_sx_ff <= a_sx_ff;
         b_sy_ff <= a_sy_ff;
         b_dx_ff <= a_dx_ff;
         b_dy_ff <= a_dy_ff;
      end
   end

   lsfc_mul u_mul0 (.clock, .en, .bound(neg_b), .s_this(a_sx_ff), .d_other(a_dy_ff),
                    .prod_ff(prod[0]));
   lsfc_mul u_mul1 (.clock, .en, .bound(pos_b), .s_this(a_sx_ff), .d_other(a_dy_ff),
                    .prod_ff(prod[1]));
   lsfc_mul u_mul2 (.clock, .en, .bound(neg_b), .s_this(a_sy_ff), .d_other(a_dx_ff),
                    .prod_ff(prod[2]));
   lsfc_mul u_mul3 (.clock, .en, .bound(pos_b), .s_this(a_sy_ff), .d_other(a_dx_ff),
                    .prod_ff(prod[3]));

   lsfc_div u_div0 (.clock, .en, .prod(prod[0]), .den(b_dx_ff), .quot(quot[0]),
                    .neg(qneg[0]), .ovf(qovf[0]));
   lsfc_div u_div1 (.clock, .en, .prod(prod[1]), .den(b_dx_ff), .quot(quot[1]),
                    .neg(qneg[1]), .ovf(qovf[1]));
   lsfc_div u_div2 (.clock, .en, .prod(prod[2]), .den(b_dy_ff), .quot(quot[2]),
                    .neg(qneg[2]), .ovf(qovf[2]));
   lsfc_div u_div3 (.clock, .en, .prod(prod[3]), .den(b_dy_ff), .quot(quot[3]),
                    .neg(qneg[3]), .ovf(qovf[3]));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DivLat; i++) begin
            sv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         sv_ff[0] <= b_valid_ff;
         for (int i = 1; i < DivLat; i++) begin
            sv_ff[i] <= sv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= '{sx: b_sx_ff, sy: b_sy_ff, nzx: |b_dx_ff, nzy: |b_dy_ff};
         for (int i = 1; i < DivLat; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_cross
      logic signed [33:0] qs;
      logic signed [34:0] res;
      logic signed [34:0] other;
      logic signed [34:0] rpos;
      logic               nz;
      logic               inr;
      assign qs    = qneg[i] ? -$signed({1'b0, quot[i]}) : $signed({1'b0, quot[i]});
      assign other = (i < 2) ? 35'(sd_ff[DivLat-1].sy) : 35'(sd_ff[DivLat-1].sx);
      assign nz    = (i < 2) ? sd_ff[DivLat-1].nzx : sd_ff[DivLat-1].nzy;
      assign res   = other + 35'(qs);
      assign rpos  = {4'b0000, fov_ff};
      assign inr   = (res >= -rpos) && (res <= rpos) && !qovf[i] && nz;
      always_comb begin
         c_in[i].keep = inr;
         if (i < 2) begin
            c_in[i].x = (i == 0) ? neg_b[31:0] : pos_b[31:0];
            c_in[i].y = res[31:0];
         end else begin
            c_in[i].x = res[31:0];
            c_in[i].y = (i == 2) ? neg_b[31:0] : pos_b[31:0];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            c_ff[i] <= c_in[i];
         end
      end
   end

   lsfc_pick u_pick (
      .clock, .reset, .en, .valid(c_valid_ff), .cr(c_ff),
      .valid_ff(rsp_valid), .crosses_ff(rsp_crosses_fov),
      .first_x_ff(rsp_first_x), .first_y_ff(rsp_first_y),
      .second_x_ff(rsp_second_x), .second_y_ff(rsp_second_y)
   );

   assign miss_clear     = (rsp_first_x == 0) && (rsp_first_y == 0) &&
                           (rsp_second_x == 0) && (rsp_second_y == 0);
   assign first_in_sq    = (33'(rsp_first_x) <= pos_b) && (33'(rsp_first_x) >= neg_b);
   assign second_on_edge = (33'(rsp_second_x) == pos_b) || (33'(rsp_second_x) == neg_b) ||
                           (33'(rsp_second_y) == pos_b) || (33'(rsp_second_y) == neg_b);

   `LSFC_ASSERT_IMPL(a_miss_zero, rsp_valid && !rsp_crosses_fov, miss_clear, "missed line with nonzero points")
   `LSFC_ASSERT_IMPL(a_first_in, rsp_valid && rsp_crosses_fov, first_in_sq, "first crossing outside square")
   `LSFC_ASSERT_IMPL(a_on_edge, rsp_valid && rsp_crosses_fov, second_on_edge, "second crossing off the boundary")
endmodule
`default_nettype wire

>>> hdl/lsfc_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module lsfc_mul (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [32:0] bound,
   input  wire logic signed [31:0] s_this,
   input  wire logic signed [31:0] d_other,
   output logic signed [64:0]      prod_ff
);
   logic signed [32:0] diff;
   logic signed [64:0] prod_in;

   assign diff    = bound - {s_this[31], s_this};
   assign prod_in = diff * d_other;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end
endmodule
`default_nettype wire

>>> hdl/lsfc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module lsfc_div import lsfc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [64:0] prod,
   input  wire logic signed [31:0] den,
   output logic [QuotBits-1:0]     quot,
   output logic                    neg,
   output logic                    ovf
);
   logic [63:0]          rem_ff  [0:QuotBits];
   logic [QuotBits-1:0]  q_ff    [0:QuotBits];
   logic [31:0]          d_ff    [0:QuotBits];
   logic                 neg_ff  [0:QuotBits];
   logic                 ovf_ff  [0:QuotBits];
   logic [64:0]          nmag_in;
   logic [31:0]          dmag_in;

   assign nmag_in = prod[64] ? 65'(-prod) : 65'(prod);
   assign dmag_in = den[31] ? 32'(-den) : 32'(den);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= nmag_in[63:0];
         q_ff[0]   <= '0;
         d_ff[0]   <= dmag_in;
         neg_ff[0] <= prod[64] ^ den[31];
         ovf_ff[0] <= nmag_in >= {dmag_in, 33'b0};
      end
   end

   for (genvar j = 0; j < QuotBits; j++) begin : g_step
      localparam int K = QuotBits - 1 - j;
      logic [63:0] sub;
      logic        ge;
      assign sub = 64'(d_ff[j]) << K;
      assign ge  = rem_ff[j] >= sub;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= ge ? rem_ff[j] - sub : rem_ff[j];
            q_ff[j+1]   <= q_ff[j] | (ge ? (QuotBits'(1) << K) : '0);
            d_ff[j+1]   <= d_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            ovf_ff[j+1] <= ovf_ff[j];
         end
      end
   end

   assign quot = q_ff[QuotBits];
   assign neg  = neg_ff[QuotBits];
   assign ovf  = ovf_ff[QuotBits] | (|rem_ff[QuotBits] & 1'b0);
endmodule
`default_nettype wire

>>> hdl/lsfc_pick.sv
`timescale 1ns / 1ps
`default_nettype none
module lsfc_pick import lsfc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         valid,
   input  wire crossing_type cr [4],
   output logic              valid_ff,
   output logic              crosses_ff,
   output logic signed [31:0] first_x_ff,
   output logic signed [31:0] first_y_ff,
   output logic signed [31:0] second_x_ff,
   output logic signed [31:0] second_y_ff
);
   logic [2:0]   count;
   crossing_type fst, snd;
   logic         got;

   always_comb begin
      count = '0;
      fst   = '0;
      snd   = '0;
      got   = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (cr[i].keep) begin
            count = count + 3'd1;
            if (!got) begin
               fst = cr[i];
               got = 1'b1;
            end else if (count == 3'd2) begin
               snd = cr[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         crosses_ff  <= count == 3'd2;
         first_x_ff  <= (count == 3'd2) ? fst.x : '0;
         first_y_ff  <= (count == 3'd2) ? fst.y : '0;
         second_x_ff <= (count == 3'd2) ? snd.x : '0;
         second_y_ff <= (count == 3'd2) ? snd.y : '0;
      end
   end
endmodule
`default_nettype wire
